### rtl/core/tgd_pkg.sv
`timescale 1ns / 1ps

package tgd_pkg;

  localparam int GRID_SIDE  = 32;
  localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE * GRID_SIDE;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int AXIS_W     = $clog2(GRID_SIDE);
  localparam int N_W        = $clog2(GRID_SIDE + 1);
  localparam int POS_W      = 16;
  localparam int MASS_W     = 24;
  localparam int CELL_W     = 32;
  localparam int WGT_W      = 16;
  localparam int PROD_W     = 48;
  localparam int ACC_W      = PROD_W + 5;
  localparam int SCL_W      = ACC_W - 16;
  localparam int PART_W     = SCL_W + 16;
  localparam int R_W        = POS_W + N_W;

  typedef enum logic [1:0] {
    FN_CLEAR   = 2'd0,
    FN_DEPOSIT = 2'd1,
    FN_SAMPLE  = 2'd2,
    FN_NONE    = 2'd3
  } func_t;

  typedef enum logic {
    REG_COUNT_MODE = 1'b0,
    REG_INV_MEAN   = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_AXIS,
    ST_CELL,
    ST_DRAIN,
    ST_SCALE_LO,
    ST_SCALE_HI,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic load;
    logic clr_start;
    logic clr_step;
    logic axis_step;
    logic cell_step;
    logic scale_lo;
    logic scale_hi;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic axis_last;
    logic cell_last;
    logic pipe_busy;
    logic sample_item;
    logic out_full;
  } dp_sts_t;

  function automatic logic [AXIS_W-1:0] wrap_node(logic [AXIS_W-1:0] node, logic [1:0] d);
    logic [AXIS_W-1:0] res;
    case (d)
      2'd0:    res = (node == '0) ? AXIS_W'(GRID_SIDE - 1) : node - 1'b1;
      2'd2:    res = (node == AXIS_W'(GRID_SIDE - 1)) ? '0 : node + 1'b1;
      default: res = node;
    endcase
    return res;
  endfunction

endpackage

### rtl/core/tgd_ctrl.sv
`timescale 1ns / 1ps

module tgd_ctrl import tgd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic [1:0] in_func,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          case (in_func)
            FN_CLEAR: begin
              cmd.clr_start = 1'b1;
              state_next    = ST_CLEAR;
            end
            FN_DEPOSIT, FN_SAMPLE: state_next = ST_AXIS;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_AXIS: begin
        cmd.axis_step = 1'b1;
        if (sts.axis_last) state_next = ST_CELL;
      end
      ST_CELL: begin
        cmd.cell_step = 1'b1;
        if (sts.cell_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) state_next = sts.sample_item ? ST_SCALE_LO : ST_IDLE;
      end
      ST_SCALE_LO: begin
        cmd.scale_lo = 1'b1;
        state_next   = ST_SCALE_HI;
      end
      ST_SCALE_HI: begin
        cmd.scale_hi = 1'b1;
        state_next   = ST_RESULT;
      end
      ST_RESULT: begin
        if (!sts.out_full) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

endmodule

### rtl/core/tgd_datapath.sv
`timescale 1ns / 1ps

module tgd_datapath import tgd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  dp_cmd_t             cmd,
  output dp_sts_t             sts,
  input  logic [1:0]          in_func,
  input  logic [POS_W-1:0]    in_pos_x,
  input  logic [POS_W-1:0]    in_pos_y,
  input  logic [POS_W-1:0]    in_pos_z,
  input  logic [MASS_W-1:0]   in_mass,
  input  logic                in_last,
  input  logic                cfg_we,
  input  logic                cfg_idx,
  input  logic [31:0]         cfg_wdata,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [CELL_W-1:0]   out_density,
  output logic                out_saturated,
  output logic                out_last
);

  logic [CELL_W-1:0] mem [CELL_COUNT];
  logic [CELL_W-1:0] mem_q;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;

  logic              count_mode;
  logic [31:0]       inv_mean;

  logic [1:0]        fn_q;
  logic [POS_W-1:0]  px, py, pz;
  logic [MASS_W-1:0] mass_q;
  logic              last_q;

  logic [ADDR_W-1:0] clr_addr;
  logic [1:0]        ax;
  logic [1:0]        dx, dy, dz;
  logic [AXIS_W-1:0] nd_x, nd_y, nd_z;
  logic [WGT_W-1:0]  wx [3];
  logic [WGT_W-1:0]  wy [3];
  logic [WGT_W-1:0]  wz [3];

  logic [POS_W-1:0]  pos_sel;
  logic [R_W-1:0]    r;
  logic [R_W:0]      rr;
  logic [N_W-1:0]    n_raw;
  logic [AXIS_W-1:0] node_v;
  logic signed [16:0] h;
  logic signed [33:0] hsq, h_sh, tm, t0, tp;

  logic [ADDR_W-1:0] addr0, addr1, addr2, addr3;
  logic [31:0]       wxy_full, w_full;
  logic [WGT_W-1:0]  wxy1, wz1, w2;
  logic              v1, v2, v3;
  logic [CELL_W-1:0] rdata2, rdata3;
  logic [PROD_W-1:0] prod3;
  logic [CELL_W-1:0] mul_a;
  logic [MASS_W-1:0] mul_b;
  logic [CELL_W:0]   sum33;
  logic [ACC_W-1:0]  acc;
  logic              cell_ovf;
  logic              deposit;

  logic [SCL_W-1:0]  s_val;
  logic [PART_W-1:0] p_lo, p_hi;
  logic [PART_W:0]   d_sum;

  assign deposit = (fn_q == FN_DEPOSIT);
  assign s_val   = acc[ACC_W-1:16];

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      count_mode <= 1'b0;
      inv_mean   <= 32'h0001_0000;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_COUNT_MODE: count_mode <= cfg_wdata[0];
        REG_INV_MEAN:   inv_mean   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // axis weights
  always_comb begin
    case (ax)
      2'd0:    pos_sel = px;
      2'd1:    pos_sel = py;
      default: pos_sel = pz;
    endcase
    r      = R_W'(pos_sel) * R_W'(GRID_SIDE);
    rr     = {1'b0, r} + (R_W + 1)'(32768);
    n_raw  = rr[R_W-1:16];
    node_v = (n_raw == N_W'(GRID_SIDE)) ? '0 : n_raw[AXIS_W-1:0];
    h      = {r[15], r[15:0]};
    hsq    = h * h;
    h_sh   = {{1{h[16]}}, h, 16'd0};
    tm     = 34'sh040000000 - h_sh + hsq;
    tp     = 34'sh040000000 + h_sh + hsq;
    t0     = 34'sh180000000 - (hsq <<< 1);
  end

  always_comb begin
    addr0    = ADDR_W'(wrap_node(nd_z, dz)) * ADDR_W'(GRID_SIDE * GRID_SIDE)
             + ADDR_W'(wrap_node(nd_y, dy)) * ADDR_W'(GRID_SIDE)
             + ADDR_W'(wrap_node(nd_x, dx));
    wxy_full = wx[dx] * wy[dy];
    w_full   = wxy1 * wz1;
    mul_a    = deposit ? CELL_W'(w2) : rdata2;
    mul_b    = deposit ? (count_mode ? MASS_W'(32'h0001_0000) : mass_q) : MASS_W'(w2);
    sum33    = {1'b0, rdata3} + {1'b0, prod3[47:16]};
    d_sum    = {1'b0, p_hi} + (PART_W + 1)'(p_lo[PART_W-1:16]);
  end

  assign mem_we    = cmd.clr_step | (v3 & deposit);
  assign mem_waddr = cmd.clr_step ? clr_addr : addr3;
  assign mem_wdata = cmd.clr_step ? '0 : (sum33[CELL_W] ? '1 : sum33[CELL_W-1:0]);

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_q <= mem[addr0];
  end

  // control counters and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      ax        <= '0;
      dx        <= '0;
      dy        <= '0;
      dz        <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      cell_ovf  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clr_start) begin
        clr_addr <= '0;
        cell_ovf <= 1'b0;
      end else if (cmd.clr_step) begin
        clr_addr <= sts.clr_last ? '0 : clr_addr + 1'b1;
      end
      if (cmd.load) begin
        ax <= '0;
        dx <= '0;
        dy <= '0;
        dz <= '0;
      end else begin
        if (cmd.axis_step) ax <= ax + 1'b1;
        if (cmd.cell_step) begin
          if (dx == 2'd2) begin
            dx <= '0;
            if (dy == 2'd2) begin
              dy <= '0;
              dz <= dz + 1'b1;
            end else begin
              dy <= dy + 1'b1;
            end
          end else begin
            dx <= dx + 1'b1;
          end
        end
      end
      v1 <= cmd.cell_step;
      v2 <= v1;
      v3 <= v2;
      if (v3 && deposit && sum33[CELL_W]) cell_ovf <= 1'b1;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fn_q   <= in_func;
      px     <= in_pos_x;
      py     <= in_pos_y;
      pz     <= in_pos_z;
      mass_q <= in_mass;
      last_q <= in_last;
      acc    <= '0;
    end else if (v3 && !deposit) begin
      acc <= acc + ACC_W'(prod3);
    end
    if (cmd.axis_step) begin
      case (ax)
        2'd0: begin
          nd_x <= node_v;
          wx[0] <= tm[32:17];
          wx[1] <= t0[32:17];
          wx[2] <= tp[32:17];
        end
        2'd1: begin
          nd_y <= node_v;
          wy[0] <= tm[32:17];
          wy[1] <= t0[32:17];
          wy[2] <= tp[32:17];
        end
        default: begin
          nd_z <= node_v;
          wz[0] <= tm[32:17];
          wz[1] <= t0[32:17];
          wz[2] <= tp[32:17];
        end
      endcase
    end
    addr1  <= addr0;
    wxy1   <= wxy_full[31:16];
    wz1    <= wz[dz];
    addr2  <= addr1;
    w2     <= w_full[31:16];
    rdata2 <= mem_q;
    addr3  <= addr2;
    rdata3 <= rdata2;
    prod3  <= PROD_W'(mul_a * mul_b);
    if (cmd.scale_lo) p_lo <= PART_W'(s_val) * PART_W'(inv_mean[15:0]);
    if (cmd.scale_hi) p_hi <= PART_W'(s_val) * PART_W'(inv_mean[31:16]);
    if (cmd.out_load) begin
      out_density   <= (d_sum[PART_W:32] != '0) ? '1 : d_sum[31:0];
      out_saturated <= cell_ovf | (d_sum[PART_W:32] != '0);
      out_last      <= last_q;
    end
  end

  always_comb begin
    sts.clr_last    = (clr_addr == ADDR_W'(CELL_COUNT - 1));
    sts.axis_last   = (ax == 2'd2);
    sts.cell_last   = (dx == 2'd2) && (dy == 2'd2) && (dz == 2'd2);
    sts.pipe_busy   = v1 | v2 | v3;
    sts.sample_item = (fn_q == FN_SAMPLE);
    sts.out_full    = out_valid;
  end

endmodule

### rtl/core/tsc_grid_deposit_and_interpolate_unit.sv
`timescale 1ns / 1ps
// channel   dir  payload
// s_axis    in   tdata pos_x/pos_y/pos_z/mass, tuser func, tlast last_item
// m_axis    out  tdata density, tuser saturated, tlast last_result
// cfg       in   cfg_index register, cfg_data value
//
// Deposit and sample each run from request to idle as one load, one axis step
// per axis on the shared squarer, 27 cells at one grid memory read a cycle, a
// drain of the three-stage cell pipeline, and for sample two scaling multiplies
// and a result.
// Clear runs a load and then a sweep over all GRID_SIDE^3 cells; after reset a
// clearing pass over every cell runs before the first request is taken. A
// waiting result stalls the next sample only at its result step.

module tsc_grid_deposit_and_interpolate_unit import tgd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // pos_x, pos_y, pos_z, mass
  input  logic [1:0]  s_axis_tuser,   // func
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // density
  output logic [0:0]  m_axis_tuser,   // saturated
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  tgd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_func  (s_axis_tuser),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tgd_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .in_func       (s_axis_tuser),
    .in_pos_x      (s_axis_tdata[15:0]),
    .in_pos_y      (s_axis_tdata[31:16]),
    .in_pos_z      (s_axis_tdata[47:32]),
    .in_mass       (s_axis_tdata[71:48]),
    .in_last       (s_axis_tlast),
    .cfg_we        (cfg_valid),
    .cfg_idx       (cfg_index),
    .cfg_wdata     (cfg_data),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_density   (m_axis_tdata),
    .out_saturated (m_axis_tuser[0]),
    .out_last      (m_axis_tlast)
  );

`ifndef SYNTHESIS
  a_idle_no_pipe: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !sts.pipe_busy) else $error("pipeline busy while idle");
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == FN_CLEAR) |=> !s_axis_tready)
    else $error("clear request did not start sweep");
  a_out_drop: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready) |=> !m_axis_tvalid)
    else $error("result reloaded while taken");
`endif

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import tgd_pkg::*;

  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct packed {
    func_t       func;
    logic [15:0] px;
    logic [15:0] py;
    logic [15:0] pz;
    logic [23:0] mass;
    logic        last;
  } request_t;

  typedef struct packed {
    logic [31:0] density;
    logic        sat;
    logic        last;
  } density_t;

  typedef struct packed {
    int             node;
    logic [2:0][15:0] w;
  } axis_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  reg_idx_t    cfg_index = REG_COUNT_MODE;
  logic [31:0] cfg_data = '0;

  request_t    req_q[$];
  density_t    density_q[$];
  request_t    cur_req;
  logic [31:0] grid [CELL_COUNT];
  logic        grid_ovf;
  logic        mode_count;
  logic [31:0] inv_mean;
  longint      cycles = 0;
  int          errors = 0;
  int          samples_sent = 0;
  int          hold_cnt = 0;
  logic        hold_done = 1'b0;
  logic        last_was_clear = 1'b0;

  tsc_grid_deposit_and_interpolate_unit dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic axis_t axis_split(logic [15:0] p);
    axis_t  a;
    longint r, n, h, lo, hi;
    r = longint'(p) * GRID_SIDE;
    n = (r + 32768) >>> 16;
    h = r - (n << 16);
    lo = 32768 - h;
    hi = 32768 + h;
    a.w[0] = 16'((lo * lo) >>> 17);
    a.w[1] = 16'((64'sd6442450944 - 2 * h * h) >>> 17);
    a.w[2] = 16'((hi * hi) >>> 17);
    a.node = int'(n % GRID_SIDE);
    return a;
  endfunction

  task automatic clear_grid();
    foreach (grid[i]) grid[i] = '0;
    grid_ovf = 1'b0;
  endtask

  task automatic apply_request(request_t rq);
    axis_t           ax, ay, az;
    longint unsigned acc, w, sum, m, s, d;
    int              ix, iy, iz, idx;
    density_t        res;
    acc = 0;
    if (rq.func == FN_CLEAR) begin
      clear_grid();
      return;
    end
    if (rq.func == FN_NONE) return;
    ax = axis_split(rq.px);
    ay = axis_split(rq.py);
    az = axis_split(rq.pz);
    m = mode_count ? 64'h10000 : 64'(rq.mass);
    for (int dz = 0; dz < 3; dz++) begin
      iz = (az.node + dz - 1 + GRID_SIDE) % GRID_SIDE;
      for (int dy = 0; dy < 3; dy++) begin
        iy = (ay.node + dy - 1 + GRID_SIDE) % GRID_SIDE;
        for (int dx = 0; dx < 3; dx++) begin
          ix = (ax.node + dx - 1 + GRID_SIDE) % GRID_SIDE;
          idx = (iz * GRID_SIDE + iy) * GRID_SIDE + ix;
          w = (((64'(ax.w[dx]) * 64'(ay.w[dy])) >> 16) * 64'(az.w[dz])) >> 16;
          if (rq.func == FN_DEPOSIT) begin
            sum = 64'(grid[idx]) + ((w * m) >> 16);
            if (sum > 64'hFFFFFFFF) begin
              sum = 64'hFFFFFFFF;
              grid_ovf = 1'b1;
            end
            grid[idx] = sum[31:0];
          end else begin
            acc += 64'(grid[idx]) * w;
          end
        end
      end
    end
    if (rq.func == FN_DEPOSIT) return;
    s = acc >> 16;
    d = s * 64'(inv_mean[31:16]) + ((s * 64'(inv_mean[15:0])) >> 16);
    res.sat = grid_ovf;
    if (d > 64'hFFFFFFFF) begin
      d = 64'hFFFFFFFF;
      res.sat = 1'b1;
    end
    res.density = d[31:0];
    res.last = rq.last;
    density_q.push_back(res);
  endtask

  function automatic logic [15:0] rand_pos();
    if ($urandom_range(0, 1)) return 16'($urandom);
    return 16'((($urandom_range(0, 3)) << 11) | $urandom_range(0, 2047));
  endfunction

  function automatic request_t rand_request(logic allow_clear);
    request_t rq;
    int       pick;
    pick = $urandom_range(0, 999);
    rq.px = rand_pos();
    rq.py = rand_pos();
    rq.pz = rand_pos();
    rq.mass = ($urandom_range(0, 9) == 0) ? 24'hFFFFFF : 24'($urandom);
    rq.last = 1'($urandom);
    if (allow_clear && pick < 4) rq.func = FN_CLEAR;
    else if (pick < 35) rq.func = FN_NONE;
    else if (pick < 620) rq.func = FN_DEPOSIT;
    else rq.func = FN_SAMPLE;
    return rq;
  endfunction

  function automatic request_t mk(func_t f, logic [15:0] x, logic [15:0] y, logic [15:0] z,
                                  logic [23:0] m, logic l);
    request_t rq;
    rq.func = f; rq.px = x; rq.py = y; rq.pz = z; rq.mass = m; rq.last = l;
    return rq;
  endfunction

  task automatic wait_idle();
    do @(posedge clk);
    while (req_q.size() != 0 || s_axis_tvalid || density_q.size() != 0);
    repeat (last_was_clear ? CELL_COUNT + 100 : 60) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_COUNT_MODE) mode_count = val[0];
    else inv_mean = val;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        apply_request(cur_req);
        last_was_clear = (cur_req.func == FN_CLEAR);
        if (cur_req.func == FN_SAMPLE) samples_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (req_q.size() != 0 &&
            ((cycles > 70000 && cycles < 100000) || $urandom_range(0, 99) >= 27)) begin
          cur_req = req_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {cur_req.mass, cur_req.pz, cur_req.py, cur_req.px};
          s_axis_tuser <= cur_req.func;
          s_axis_tlast <= cur_req.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    density_t exp_res;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (density_q.size() == 0) begin
          $display("%0t: unexpected result density=%h sat=%b last=%b", $time,
                   m_axis_tdata, m_axis_tuser, m_axis_tlast);
          errors++;
        end else begin
          exp_res = density_q.pop_front();
          if (m_axis_tdata !== exp_res.density) begin
            $display("%0t: density expected %h actual %h", $time, exp_res.density, m_axis_tdata);
            errors++;
          end
          if (m_axis_tuser[0] !== exp_res.sat) begin
            $display("%0t: saturated expected %b actual %b", $time, exp_res.sat, m_axis_tuser);
            errors++;
          end
          if (m_axis_tlast !== exp_res.last) begin
            $display("%0t: last expected %b actual %b", $time, exp_res.last, m_axis_tlast);
            errors++;
          end
        end
      end
      if (!hold_done && samples_sent >= 200) begin
        hold_done <= 1'b1;
        hold_cnt <= 3000;
        m_axis_tready <= 1'b0;
      end else if (hold_cnt != 0) begin
        hold_cnt <= hold_cnt - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= (cycles > 70000 && cycles < 100000) || ($urandom_range(0, 99) >= 27);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    clear_grid();
    mode_count = 1'b0;
    inv_mean = 32'h10000;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    write_reg(REG_COUNT_MODE, 32'd0);
    write_reg(REG_INV_MEAN, 32'h10000);
    req_q.push_back(mk(FN_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 24'h0, 1'b1));
    req_q.push_back(mk(FN_DEPOSIT, 16'h0000, 16'h0000, 16'h0000, 24'hFFFFFF, 1'b0));
    req_q.push_back(mk(FN_DEPOSIT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'h010000, 1'b1));
    req_q.push_back(mk(FN_DEPOSIT, 16'h0400, 16'h03FF, 16'h8000, 24'h123456, 1'b0));
    req_q.push_back(mk(FN_DEPOSIT, 16'h8000, 16'h0400, 16'h03FF, 24'h000000, 1'b0));
    req_q.push_back(mk(FN_NONE, 16'h0000, 16'h0000, 16'h0000, 24'hFFFFFF, 1'b1));
    req_q.push_back(mk(FN_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 24'h0, 1'b0));
    req_q.push_back(mk(FN_SAMPLE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 1'b1));
    req_q.push_back(mk(FN_SAMPLE, 16'h0400, 16'h03FF, 16'h8000, 24'h0, 1'b0));
    req_q.push_back(mk(FN_SAMPLE, 16'h8000, 16'h0400, 16'h03FF, 24'h0, 1'b1));
    req_q.push_back(mk(FN_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 1'b1));
    req_q.push_back(mk(FN_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 24'h0, 1'b1));
    wait_idle();

    write_reg(REG_COUNT_MODE, 32'd1);
    write_reg(REG_INV_MEAN, 32'hFFFFFFFF);
    for (int i = 0; i < 4; i++)
      req_q.push_back(mk(FN_DEPOSIT, 16'h1234, 16'h4321, 16'hF00F, 24'h0, 1'b0));
    req_q.push_back(mk(FN_SAMPLE, 16'h1234, 16'h4321, 16'hF00F, 24'h0, 1'b1));
    req_q.push_back(mk(FN_SAMPLE, 16'h9999, 16'h1111, 16'h2222, 24'h0, 1'b0));
    wait_idle();
    write_reg(REG_INV_MEAN, 32'h0);
    req_q.push_back(mk(FN_SAMPLE, 16'h1234, 16'h4321, 16'hF00F, 24'h0, 1'b1));
    wait_idle();

    // pile max-weight deposits on one node until its cell clamps
    write_reg(REG_COUNT_MODE, 32'd0);
    write_reg(REG_INV_MEAN, 32'h10000);
    for (int i = 0; i < 640; i++) begin
      req_q.push_back(mk(FN_DEPOSIT, 16'h4000, 16'h4000, 16'h4000, 24'hFFFFFF, 1'b0));
      if (i % 40 == 39) req_q.push_back(mk(FN_SAMPLE, 16'h4000, 16'h4000, 16'h4000, 24'h0, 1'b1));
    end
    req_q.push_back(mk(FN_SAMPLE, 16'h4000, 16'h4000, 16'h4000, 24'h0, 1'b0));
    req_q.push_back(mk(FN_CLEAR, 16'h0, 16'h0, 16'h0, 24'h0, 1'b0));
    req_q.push_back(mk(FN_SAMPLE, 16'h4000, 16'h4000, 16'h4000, 24'h0, 1'b1));
    wait_idle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_COUNT_MODE, 32'd0);
          write_reg(REG_INV_MEAN, $urandom);
        end
        1: begin
          write_reg(REG_COUNT_MODE, 32'd1);
          write_reg(REG_INV_MEAN, 32'h10000);
        end
        2: begin
          write_reg(REG_COUNT_MODE, 32'd0);
          write_reg(REG_INV_MEAN, 32'hFFFFFFFF);
        end
        default: begin
          write_reg(REG_COUNT_MODE, 32'($urandom_range(0, 1)));
          write_reg(REG_INV_MEAN, 32'($urandom_range(0, 32'h40000)));
        end
      endcase
      for (int i = 0; i < 250; i++) req_q.push_back(rand_request(ph != 0));
      wait_idle();
    end

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
